// File: rtl/skct_pkg.sv
// shared types, constants and codes of the sorted key count table
`timescale 1ns / 1ps

package skct_pkg;

    localparam int SKCT_MAX_KEYS = 256;
    localparam int SKCT_NAME_LEN = 64;

    localparam int CHAR_W   = 8;
    localparam int RANK_W   = 8;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 3;
    localparam int DK_W     = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [STATUS_W-1:0] ST_COUNTED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY_RANK = 3'd4;

    localparam logic ACT_NAME_BYTE = 1'b0;
    localparam logic ACT_READ      = 1'b1;

    typedef struct packed {
        logic rot;
        logic ins;
        logic wr_head;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD,
        S_CMP_REQ,
        S_CMP_CHK,
        S_FIN,
        S_CP_REQ,
        S_CP_WR,
        S_INS,
        S_EMIT_ST,
        S_RD_ROT,
        S_RD_REQ,
        S_RD_OUT,
        S_RD_REST
    } t_state;

endpackage

// File: rtl/skct_cell.sv
// one rank cell of the sorted ring: slot, length and count of one entry
`timescale 1ns / 1ps

module skct_cell import skct_pkg::*; #(
    parameter int IDX = 0,
    parameter int SW  = $clog2(SKCT_MAX_KEYS),
    parameter int UW  = $clog2(SKCT_MAX_KEYS + 1),
    parameter int LW  = $clog2(SKCT_NAME_LEN + 1)
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [UW-1:0]      i_used_m1,
    input  logic [UW-1:0]      i_pos,
    input  logic [SW-1:0]      i_nxt_slot,
    input  logic [LW-1:0]      i_nxt_len,
    input  logic [COUNT_W-1:0] i_nxt_cnt,
    input  logic [SW-1:0]      i_prv_slot,
    input  logic [LW-1:0]      i_prv_len,
    input  logic [COUNT_W-1:0] i_prv_cnt,
    input  logic [SW-1:0]      i_head_slot,
    input  logic [LW-1:0]      i_head_len,
    input  logic [COUNT_W-1:0] i_head_cnt,
    input  logic [SW-1:0]      i_new_slot,
    input  logic [LW-1:0]      i_new_len,
    input  logic [COUNT_W-1:0] i_new_cnt,
    output logic [SW-1:0]      o_slot,
    output logic [LW-1:0]      o_len,
    output logic [COUNT_W-1:0] o_cnt
);

    localparam logic [UW-1:0] MY_IDX = UW'(IDX);

    logic [SW-1:0]      r_slot;
    logic [LW-1:0]      r_len;
    logic [COUNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rot) begin
            if (MY_IDX == i_used_m1) begin
                r_slot <= i_head_slot;
                r_len  <= i_head_len;
                r_cnt  <= i_head_cnt;
            end else begin
                r_slot <= i_nxt_slot;
                r_len  <= i_nxt_len;
                r_cnt  <= i_nxt_cnt;
            end
        end else if (i_ctl.ins) begin
            if (MY_IDX > i_pos) begin
                r_slot <= i_prv_slot;
                r_len  <= i_prv_len;
                r_cnt  <= i_prv_cnt;
            end else if (MY_IDX == i_pos) begin
                r_slot <= i_new_slot;
                r_len  <= i_new_len;
                r_cnt  <= i_new_cnt;
            end
        end else if (i_ctl.wr_head && (IDX == 0)) begin
            r_cnt <= i_new_cnt;
        end
    end

    assign o_slot = r_slot;
    assign o_len  = r_len;
    assign o_cnt  = r_cnt;

endmodule

// File: rtl/sorted_key_count_table.sv
// top level: name buffer, name store, rank ring of cells and control
//
// channel | dir | fields (low bit up)
// s_axis  | in  | tdata: char_code[7:0] rank[15:8]; tuser: action; tlast: word_end
// m_axis  | out | tdata: out_char[7:0] entry_count[23:8] distinct_keys[32:24];
//         |     | tuser: status; tlast: last_of_run
//
// a name end walks the ring over all U distinct keys (one ring
//   rotation each), comparing bytes and copying a new name through the single
//   port name store
// a read walks the same ring and reads the name through the same store port
// reset clears only control state; stores are written before read
// a stalled output holds the control in its emit state or its read output state
`timescale 1ns / 1ps

module sorted_key_count_table import skct_pkg::*; #(
    parameter int MAX_KEYS = SKCT_MAX_KEYS,
    parameter int NAME_LEN = SKCT_NAME_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // char_code, rank
    input  logic        i_s_axis_tlast,
    input  logic        i_s_axis_tuser,  // action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // out_char, entry_count, distinct_keys
    output logic        o_m_axis_tlast,
    output logic [2:0]  o_m_axis_tuser   // status
);

    localparam int SW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int UW = $clog2(MAX_KEYS + 1);
    localparam int LW = $clog2(NAME_LEN + 1);
    localparam int IW = $clog2(NAME_LEN);
    localparam int AW = SW + IW;
    localparam int SDEPTH = MAX_KEYS * (1 << IW);
    localparam int CW = (UW > RANK_W) ? UW : RANK_W;

    t_state r_state, n_state;

    logic [UW-1:0]       r_used;
    logic [LW-1:0]       r_plen, n_plen;
    logic                r_trunc;
    logic [UW-1:0]       r_r;
    logic [UW-1:0]       r_pos;
    logic                r_dec;
    logic                r_found;
    logic [LW-1:0]       r_bi;
    logic [RANK_W-1:0]   r_rank;
    logic [COUNT_W-1:0]  r_rcnt;
    logic [STATUS_W-1:0] r_st;

    logic [CHAR_W-1:0] pend_mem [NAME_LEN];
    logic [CHAR_W-1:0] store_mem [SDEPTH];
    logic [CHAR_W-1:0] r_pdata;
    logic [CHAR_W-1:0] r_sdata;

    logic                r_ovalid;
    logic [CHAR_W-1:0]   r_out_char;
    logic                r_out_last;
    logic [COUNT_W-1:0]  r_out_cnt;
    logic [STATUS_W-1:0] r_out_st;
    logic [DK_W-1:0]     r_out_dk;

    logic [SW-1:0]      w_slot [MAX_KEYS];
    logic [LW-1:0]      w_len  [MAX_KEYS];
    logic [COUNT_W-1:0] w_cnt  [MAX_KEYS];

    t_cell_ctl          w_ctl;
    logic [COUNT_W-1:0] w_new_cnt;
    logic [COUNT_W-1:0] w_sat_cnt;
    logic [LW-1:0]      w_n;
    logic               w_s_hs;
    logic               w_pre, w_sre, w_swe;
    logic [AW-1:0]      w_saddr;
    logic               w_oload;
    logic [CHAR_W-1:0]  w_ochar;
    logic               w_olast;
    logic               w_rd_last;

    logic                w_act;
    logic [CHAR_W-1:0]   w_char;
    logic [RANK_W-1:0]   w_rank;

    assign w_act  = i_s_axis_tuser;
    assign w_char = i_s_axis_tdata[7:0];
    assign w_rank = i_s_axis_tdata[15:8];
    assign w_s_hs = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    assign w_sat_cnt = (w_cnt[0] == COUNT_MAX) ? w_cnt[0] : w_cnt[0] + COUNT_W'(1);
    assign w_n = (w_len[0] < r_plen) ? w_len[0] : r_plen;
    assign w_rd_last = (w_len[0] == '0) || ((r_bi + LW'(1)) == w_len[0]);

    always_comb begin
        n_plen = r_plen;
        if (r_plen < LW'(NAME_LEN)) begin
            n_plen = r_plen + LW'(1);
        end
    end

    // rank ring
    for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
        localparam int NX = (g == MAX_KEYS - 1) ? 0 : g + 1;
        localparam int PV = (g == 0) ? 0 : g - 1;
        skct_cell #(
            .IDX (g),
            .SW  (SW),
            .UW  (UW),
            .LW  (LW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_used_m1   (r_used - UW'(1)),
            .i_pos       (r_pos),
            .i_nxt_slot  (w_slot[NX]),
            .i_nxt_len   (w_len[NX]),
            .i_nxt_cnt   (w_cnt[NX]),
            .i_prv_slot  (w_slot[PV]),
            .i_prv_len   (w_len[PV]),
            .i_prv_cnt   (w_cnt[PV]),
            .i_head_slot (w_slot[0]),
            .i_head_len  (w_len[0]),
            .i_head_cnt  (w_cnt[0]),
            .i_new_slot  (r_used[SW-1:0]),
            .i_new_len   (r_plen),
            .i_new_cnt   (w_new_cnt),
            .o_slot      (w_slot[g]),
            .o_len       (w_len[g]),
            .o_cnt       (w_cnt[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_hs) begin
                    if (w_act == ACT_NAME_BYTE) begin
                        if (i_s_axis_tlast) n_state = S_HEAD;
                    end else if (CW'(w_rank) >= CW'(r_used)) begin
                        n_state = S_EMIT_ST;
                    end else begin
                        n_state = S_RD_ROT;
                    end
                end
            end
            S_HEAD: begin
                if (r_r == r_used) n_state = S_FIN;
                else if (!r_dec) n_state = S_CMP_REQ;
            end
            S_CMP_REQ: begin
                if (r_bi == w_n) n_state = S_HEAD;
                else n_state = S_CMP_CHK;
            end
            S_CMP_CHK: begin
                if (r_pdata == r_sdata) n_state = S_CMP_REQ;
                else n_state = S_HEAD;
            end
            S_FIN: begin
                if (r_found || (r_used >= UW'(MAX_KEYS))) n_state = S_EMIT_ST;
                else n_state = S_CP_REQ;
            end
            S_CP_REQ: begin
                if (r_bi == r_plen) n_state = S_INS;
                else n_state = S_CP_WR;
            end
            S_CP_WR:   n_state = S_CP_REQ;
            S_INS:     n_state = S_EMIT_ST;
            S_EMIT_ST: begin
                if (!r_ovalid) n_state = S_IDLE;
            end
            S_RD_ROT: begin
                if (CW'(r_r) == CW'(r_rank)) n_state = S_RD_REQ;
            end
            S_RD_REQ:  n_state = S_RD_OUT;
            S_RD_OUT: begin
                if (!r_ovalid) begin
                    if (w_rd_last) n_state = S_RD_REST;
                    else n_state = S_RD_REQ;
                end
            end
            S_RD_REST: begin
                if (r_r == r_used) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the control
    always_comb begin
        w_ctl     = '0;
        w_new_cnt = COUNT_W'(1);
        w_pre     = 1'b0;
        w_sre     = 1'b0;
        w_swe     = 1'b0;
        w_saddr   = {w_slot[0], r_bi[IW-1:0]};
        w_oload   = 1'b0;
        w_ochar   = '0;
        w_olast   = 1'b1;
        unique case (r_state)
            S_HEAD: begin
                w_ctl.rot = (r_r != r_used) && r_dec;
            end
            S_CMP_REQ: begin
                if (r_bi == w_n) begin
                    if (w_len[0] == r_plen) begin
                        w_ctl.wr_head = 1'b1;
                        w_new_cnt     = w_sat_cnt;
                    end else if (r_plen > w_len[0]) begin
                        w_ctl.rot = 1'b1;
                    end
                end else begin
                    w_pre = 1'b1;
                    w_sre = 1'b1;
                end
            end
            S_CMP_CHK: begin
                w_ctl.rot = (r_pdata > r_sdata);
            end
            S_CP_REQ: begin
                w_pre = (r_bi != r_plen);
            end
            S_CP_WR: begin
                w_swe   = 1'b1;
                w_saddr = {r_used[SW-1:0], r_bi[IW-1:0]};
            end
            S_INS: begin
                w_ctl.ins = 1'b1;
            end
            S_EMIT_ST: begin
                w_oload = !r_ovalid;
            end
            S_RD_ROT: begin
                w_ctl.rot = (CW'(r_r) != CW'(r_rank));
            end
            S_RD_REQ: begin
                w_sre = 1'b1;
            end
            S_RD_OUT: begin
                w_oload = !r_ovalid;
                w_ochar = (w_len[0] == '0) ? '0 : r_sdata;
                w_olast = w_rd_last;
            end
            S_RD_REST: begin
                w_ctl.rot = (r_r != r_used);
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_plen   <= '0;
            r_trunc  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_oload) r_ovalid <= 1'b1;
            else if (i_m_axis_tready) r_ovalid <= 1'b0;
            if (w_s_hs && (w_act == ACT_NAME_BYTE)) begin
                r_plen <= n_plen;
                if (r_plen == LW'(NAME_LEN)) r_trunc <= 1'b1;
            end
            if ((r_state == S_FIN) && (r_found || (r_used >= UW'(MAX_KEYS)))) begin
                r_plen  <= '0;
                r_trunc <= 1'b0;
            end
            if (r_state == S_INS) begin
                r_used  <= r_used + UW'(1);
                r_plen  <= '0;
                r_trunc <= 1'b0;
            end
        end
    end

    // work registers of the search, copy and read sequences
    always_ff @(posedge i_clk) begin
        if (w_ctl.rot) r_r <= r_r + UW'(1);
        unique case (r_state)
            S_IDLE: begin
                r_r     <= '0;
                r_bi    <= '0;
                r_dec   <= 1'b0;
                r_found <= 1'b0;
                r_pos   <= r_used;
                r_rank  <= w_rank;
                r_rcnt  <= '0;
                r_st    <= ST_EMPTY_RANK;
            end
            S_HEAD: begin
                r_bi <= '0;
            end
            S_CMP_REQ: begin
                if ((r_bi == w_n) && (r_plen <= w_len[0])) begin
                    r_dec <= 1'b1;
                    r_pos <= r_r;
                    if (w_len[0] == r_plen) begin
                        r_found <= 1'b1;
                        r_rcnt  <= w_sat_cnt;
                    end
                end
            end
            S_CMP_CHK: begin
                if (r_pdata == r_sdata) begin
                    r_bi <= r_bi + LW'(1);
                end else if (r_pdata < r_sdata) begin
                    r_dec <= 1'b1;
                    r_pos <= r_r;
                end
            end
            S_FIN: begin
                r_bi <= '0;
                if (r_found) begin
                    r_st <= r_trunc ? ST_TRUNCATED : ST_COUNTED;
                end else begin
                    r_st   <= ST_FULL;
                    r_rcnt <= '0;
                end
            end
            S_CP_WR: begin
                r_bi <= r_bi + LW'(1);
            end
            S_INS: begin
                r_rcnt <= COUNT_W'(1);
                r_st   <= r_trunc ? ST_TRUNCATED : ST_INSERTED;
            end
            S_RD_ROT: begin
                r_bi <= '0;
            end
            S_RD_OUT: begin
                if (!r_ovalid) r_bi <= r_bi + LW'(1);
            end
            default: begin
                r_bi <= r_bi;
            end
        endcase
    end

    // pending name buffer
    always_ff @(posedge i_clk) begin
        if (w_s_hs && (w_act == ACT_NAME_BYTE) && (r_plen < LW'(NAME_LEN))) begin
            pend_mem[r_plen[IW-1:0]] <= w_char;
        end
        if (w_pre) r_pdata <= pend_mem[r_bi[IW-1:0]];
    end

    // name store
    always_ff @(posedge i_clk) begin
        if (w_swe) store_mem[w_saddr] <= r_pdata;
        if (w_sre) r_sdata <= store_mem[w_saddr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            r_out_char <= w_ochar;
            r_out_last <= w_olast;
            r_out_dk   <= DK_W'(r_used);
            if (r_state == S_RD_OUT) begin
                r_out_cnt <= w_cnt[0];
                r_out_st  <= ST_COUNTED;
            end else begin
                r_out_cnt <= r_rcnt;
                r_out_st  <= r_st;
            end
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {7'd0, r_out_dk, r_out_cnt, r_out_char};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_st;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(MAX_KEYS))
        else $error("distinct key count beyond table size");

    a_plen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= LW'(NAME_LEN))
        else $error("pending length beyond name length");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |=> (r_used == $past(r_used) + UW'(1)))
        else $error("insert did not add an entry");

    a_ring_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_HEAD) || (r_state == S_RD_REST)) |-> (r_r <= r_used))
        else $error("ring walk passed the last entry");

    a_used_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INS) |=> $stable(r_used))
        else $error("entry count changed outside insert");

endmodule

// File: tb/sv/sorted_key_count_table_test.sv
// self-checking testbench of the sorted key count table
`timescale 1ns / 1ps

module sorted_key_count_table_test;
    import skct_pkg::*;

    localparam int WATCHDOG_LIMIT = 150000;

    typedef struct {
        logic       act;
        logic [7:0] ch;
        logic       wend;
        logic [7:0] rank;
    } t_item;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic [15:0] cnt;
        logic [2:0]  st;
        logic [8:0]  dk;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;  // char_code, rank
    logic        i_s_axis_tlast = 1'b0;
    logic        i_s_axis_tuser = 1'b0;  // action
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;  // out_char, entry_count, distinct_keys
    logic        o_m_axis_tlast;
    logic [2:0]  o_m_axis_tuser;  // status

    sorted_key_count_table u_top (.*);

    always #5 i_clk = ~i_clk;

    // sorted table kept by rank
    logic [7:0]  key_bytes [SKCT_MAX_KEYS][SKCT_NAME_LEN];
    int          key_len [SKCT_MAX_KEYS];
    logic [15:0] key_cnt [SKCT_MAX_KEYS];
    int          key_used = 0;
    logic [7:0]  word_buf [SKCT_NAME_LEN];
    int          word_len = 0;
    bit          word_cut = 0;

    t_item   stim_q [$];
    t_result result_q [$];
    int      errors = 0;
    int      in_done = 0;
    int      out_done = 0;
    int      reads_done = 0;
    bit      calm = 1;
    int      stall_cycles = 0;
    bit      stall_used = 0;
    int      quiet = 0;

    function automatic int word_vs_key(int r);
        int n;
        n = key_len[r] < word_len ? key_len[r] : word_len;
        for (int i = 0; i < n; i++) begin
            if (word_buf[i] != key_bytes[r][i]) return word_buf[i] < key_bytes[r][i] ? -1 : 1;
        end
        if (word_len == key_len[r]) return 0;
        return word_len < key_len[r] ? -1 : 1;
    endfunction

    function automatic void push_result(logic [7:0] ch, logic last, logic [15:0] cnt,
                                        logic [2:0] st);
        t_result e;
        e.ch = ch; e.last = last; e.cnt = cnt; e.st = st; e.dk = key_used[8:0];
        result_q.push_back(e);
    endfunction

    function automatic void count_word();
        int pos;
        int c;
        bit hit;
        pos = key_used;
        hit = 0;
        for (int r = 0; r < key_used; r++) begin
            c = word_vs_key(r);
            if (c <= 0) begin
                pos = r;
                hit = (c == 0);
                break;
            end
        end
        if (hit) begin
            if (key_cnt[pos] != COUNT_MAX) key_cnt[pos]++;
            push_result(8'd0, 1'b1, key_cnt[pos], word_cut ? ST_TRUNCATED : ST_COUNTED);
        end else if (key_used >= SKCT_MAX_KEYS) begin
            push_result(8'd0, 1'b1, 16'd0, ST_FULL);
        end else begin
            for (int r = key_used; r > pos; r--) begin
                key_bytes[r] = key_bytes[r-1];
                key_len[r] = key_len[r-1];
                key_cnt[r] = key_cnt[r-1];
            end
            key_bytes[pos] = word_buf;
            key_len[pos] = word_len;
            key_cnt[pos] = 16'd1;
            key_used++;
            push_result(8'd0, 1'b1, 16'd1, word_cut ? ST_TRUNCATED : ST_INSERTED);
        end
        word_len = 0;
        word_cut = 0;
    endfunction

    function automatic void predict_item(t_item it);
        if (it.act == ACT_NAME_BYTE) begin
            if (word_len < SKCT_NAME_LEN) word_buf[word_len++] = it.ch;
            else word_cut = 1;
            if (it.wend) count_word();
        end else if (it.rank >= key_used) begin
            push_result(8'd0, 1'b1, 16'd0, ST_EMPTY_RANK);
        end else begin
            for (int i = 0; i < key_len[it.rank]; i++)
                push_result(key_bytes[it.rank][i], i == key_len[it.rank] - 1,
                            key_cnt[it.rank], ST_COUNTED);
        end
    endfunction

    function automatic void add_word(logic [7:0] w [$]);
        t_item it;
        foreach (w[i]) begin
            it.act = ACT_NAME_BYTE; it.ch = w[i]; it.wend = (i == w.size() - 1);
            it.rank = 8'($urandom);
            stim_q.push_back(it);
        end
    endfunction

    function automatic void add_read(int r);
        t_item it;
        it.act = ACT_READ; it.ch = 8'($urandom); it.wend = 1'($urandom); it.rank = 8'(r);
        stim_q.push_back(it);
    endfunction

    function automatic void add_random_word();
        logic [7:0] w [$];
        int n;
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++)
            w.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(97, 100)));
        add_word(w);
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (stim_q.size() > 0 && (calm || $urandom_range(0, 99) >= 7)) begin
                t_item it;
                it = stim_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= {it.rank, it.ch};
                i_s_axis_tlast <= it.wend;
                i_s_axis_tuser <= it.act;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_cycles > 0) begin
            stall_cycles <= stall_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!stall_used && !calm && in_done > 140) begin
            stall_used <= 1;
            stall_cycles <= 400;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= calm || $urandom_range(0, 99) >= 7;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                t_item it;
                it.act = i_s_axis_tuser; it.ch = i_s_axis_tdata[7:0];
                it.wend = i_s_axis_tlast; it.rank = i_s_axis_tdata[15:8];
                if (it.act == ACT_READ) reads_done <= reads_done + 1;
                predict_item(it);
                in_done <= in_done + 1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                t_result a;
                t_result e;
                a.ch = o_m_axis_tdata[7:0]; a.cnt = o_m_axis_tdata[23:8];
                a.dk = o_m_axis_tdata[32:24]; a.st = o_m_axis_tuser; a.last = o_m_axis_tlast;
                out_done <= out_done + 1;
                if (result_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transfer ch=%h cnt=%0d st=%0d dk=%0d last=%b",
                             $time, a.ch, a.cnt, a.st, a.dk, a.last);
                end else begin
                    e = result_q.pop_front();
                    if (a != e) begin
                        errors++;
                        $display("%0t: mismatch exp ch=%h cnt=%0d st=%0d dk=%0d last=%b",
                                 $time, e.ch, e.cnt, e.st, e.dk, e.last);
                        $display("%0t:          got ch=%h cnt=%0d st=%0d dk=%0d last=%b",
                                 $time, a.ch, a.cnt, a.st, a.dk, a.last);
                    end
                end
            end
            if (quiet > WATCHDOG_LIMIT) begin
                $display("%0t: timeout, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("sorted_key_count_table_test NOT OK");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] w [$];
        // directed corner cases
        add_read(0);
        add_word('{8'h61, 8'h62});
        add_word('{8'h61});
        add_word('{8'h61, 8'h62, 8'h63});
        add_word('{8'h00});
        add_word('{8'hff, 8'h00});
        add_word('{8'hff});
        w = {};
        for (int i = 0; i < 66; i++) w.push_back(8'(i * 37 + 1));
        add_word(w);
        add_word('{8'h61});
        for (int r = 0; r < 4; r++) add_read(r);
        add_read(10);
        add_read(255);
        // random mix
        for (int i = 0; i < 8; i++) begin
            if ($urandom_range(0, 99) < 15) add_read($urandom_range(0, 10));
            else add_random_word();
        end
        // fill the table, then offer names against a full table
        for (int c = 0; c < 256; c++) add_word('{8'(c)});
        add_word('{8'h7a, 8'h7a});
        add_word('{8'h61, 8'h62});
        add_read(0);
        add_read(128);
        add_read(255);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (20) @(posedge i_clk);
        while (in_done < 100) @(posedge i_clk);
        calm = 0;
        while (stim_q.size() > 0 || i_s_axis_tvalid || result_q.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("covered %0d input transfers (%0d reads) and %0d result transfers,",
                 in_done, reads_done, out_done);
        $display("including prefix order, truncated names, empty ranks and a full table");
        if (errors == 0 && result_q.size() == 0) begin
            $display("sorted_key_count_table_test OK");
        end else begin
            $display("sorted_key_count_table_test NOT OK");
        end
        $finish;
    end
endmodule
